/* sv/lcs_pkg.sv */
// ---------------------------------------------------------------------------
// lcs_pkg: shared types and codes for the longest common substring core
// Command codes and the packed transfer types of the input and result
// channels.
// ---------------------------------------------------------------------------
package lcs_pkg;

    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int OUT_IDX_W  = 6;
    localparam int OUT_LEN_W  = 7;
    localparam int OUT_POS_W  = 6;

    localparam logic [CMD_W-1:0] CMD_APPEND_FIRST  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND_SECOND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE       = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [CHAR_W-1:0] char_value;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0]    out_char;
        logic [OUT_IDX_W-1:0] out_index;
        logic [OUT_LEN_W-1:0] match_length;
        logic [OUT_POS_W-1:0] start_pos;
        logic                 empty_res;
        logic                 overflowed;
        logic                 last;
    } out_item_t;

endpackage

/* sv/longest_common_substring_core.sv */
// ---------------------------------------------------------------------------
// longest_common_substring_core: longest common substring of two byte strings
// Loads two strings one character per transfer, then on a compute command
// runs the run-length recurrence one cell at a time over a single row
// buffer and streams out the first longest common substring, or an empty marker.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------
//  s_      | in        | s_valid / s_ready | s_data  (lcs_pkg::in_item_t)
//  m_      | out       | m_valid / m_ready | m_data  (lcs_pkg::out_item_t)
//
//  Append transfers are taken back to back.
//  Compute reads each row's first-string character in S_ROW_RD, then takes
//  each cell through S_CELL_RD and S_CELL_EX using the shared
//  compare/increment unit, bounded by the registered reads of the stores.
//  s_ready stays low from a compute transfer until its last result is loaded.
//  A stalled m_ready holds the output register and pauses the emit sequence.
//  Reset clears counts, overflow flag and control; stores need no clearing.
// ---------------------------------------------------------------------------
module longest_common_substring_core #(
    parameter int MAX_LEN = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lcs_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lcs_pkg::out_item_t  m_data
);
    import lcs_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW_RD,
        S_CELL_RD,
        S_CELL_EX,
        S_EMIT_SETUP,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   first_count_reg, first_count_next;
    logic [CW-1:0]   second_count_reg, second_count_next;
    logic            drop_reg, drop_next;
    logic [AW-1:0]   row_reg, row_next;
    logic [AW-1:0]   col_reg, col_next;
    logic [CW-1:0]   diag_reg, diag_next;
    logic [CW-1:0]   best_len_reg, best_len_next;
    logic [CW-1:0]   best_end_reg, best_end_next;
    logic [CW-1:0]   start_reg, start_next;
    logic [AW-1:0]   emit_idx_reg, emit_idx_next;
    logic            m_valid_reg, m_valid_next;
    out_item_t       m_data_reg, m_data_next;

    // memories
    logic [CHAR_W-1:0] first_mem  [MAX_LEN];
    logic [CHAR_W-1:0] second_mem [MAX_LEN];
    logic [CW-1:0]     row_mem    [MAX_LEN];
    logic [CHAR_W-1:0] fs_rdata_reg, ss_rdata_reg;
    logic [CW-1:0]     row_rdata_reg;

    logic              fs_we, ss_we, fs_re, cell_re, row_we;
    logic [AW-1:0]     fs_raddr;
    logic [CW-1:0]     cell_val;
    logic [CW-1:0]     emit_addr;
    logic              s_xfer, out_free, emit_last;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign emit_addr = start_reg + CW'(emit_idx_reg);
    assign emit_last = (CW'(emit_idx_reg) + CW'(1)) == best_len_reg;

    // shared compare and increment unit
    assign cell_val = (fs_rdata_reg == ss_rdata_reg) ? diag_reg + CW'(1) : '0;

    always_comb begin
        fs_we    = s_xfer && (s_data.command == CMD_APPEND_FIRST)
                   && (first_count_reg < CW'(MAX_LEN));
        ss_we    = s_xfer && (s_data.command == CMD_APPEND_SECOND)
                   && (second_count_reg < CW'(MAX_LEN));
        fs_re    = (state_reg == S_ROW_RD) || (state_reg == S_EMIT_RD);
        fs_raddr = (state_reg == S_ROW_RD) ? row_reg : emit_addr[AW-1:0];
        cell_re  = (state_reg == S_CELL_RD);
        row_we   = (state_reg == S_CELL_EX);
    end

    always_ff @(posedge aclk) begin
        if (fs_we) begin
            first_mem[first_count_reg[AW-1:0]] <= s_data.char_value;
        end
        if (fs_re) begin
            fs_rdata_reg <= first_mem[fs_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ss_we) begin
            second_mem[second_count_reg[AW-1:0]] <= s_data.char_value;
        end
        if (cell_re) begin
            ss_rdata_reg <= second_mem[col_reg];
        end
    end

    // row buffer: entry c holds the previous row's run length at column c+1
    always_ff @(posedge aclk) begin
        if (row_we) begin
            row_mem[col_reg] <= cell_val;
        end
        if (cell_re) begin
            row_rdata_reg <= row_mem[col_reg];
        end
    end

    always_comb begin
        state_next        = state_reg;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        drop_next         = drop_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        diag_next         = diag_reg;
        best_len_next     = best_len_reg;
        best_end_next     = best_end_reg;
        start_next        = start_reg;
        emit_idx_next     = emit_idx_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_data_next       = m_data_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    case (s_data.command)
                        CMD_APPEND_FIRST: begin
                            if (fs_we) first_count_next = first_count_reg + CW'(1);
                            else       drop_next = 1'b1;
                        end
                        CMD_APPEND_SECOND: begin
                            if (ss_we) second_count_next = second_count_reg + CW'(1);
                            else       drop_next = 1'b1;
                        end
                        CMD_COMPUTE: begin
                            best_len_next = '0;
                            best_end_next = '0;
                            row_next      = '0;
                            col_next      = '0;
                            if (first_count_reg == '0 || second_count_reg == '0) begin
                                state_next = S_EMIT_SETUP;
                            end else begin
                                state_next = S_ROW_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ROW_RD: begin
                col_next   = '0;
                diag_next  = '0;
                state_next = S_CELL_RD;
            end
            S_CELL_RD: begin
                state_next = S_CELL_EX;
            end
            S_CELL_EX: begin
                // first row sees an all-zero previous row
                diag_next = (row_reg == '0) ? '0 : row_rdata_reg;
                if (cell_val > best_len_reg) begin
                    best_len_next = cell_val;
                    best_end_next = CW'(row_reg) + CW'(1);
                end
                if ((CW'(col_reg) + CW'(1)) == second_count_reg) begin
                    if ((CW'(row_reg) + CW'(1)) == first_count_reg) begin
                        state_next = S_EMIT_SETUP;
                    end else begin
                        row_next   = row_reg + AW'(1);
                        state_next = S_ROW_RD;
                    end
                end else begin
                    col_next   = col_reg + AW'(1);
                    state_next = S_CELL_RD;
                end
            end
            S_EMIT_SETUP: begin
                start_next    = best_end_reg - best_len_reg;
                emit_idx_next = '0;
                state_next    = (best_len_reg == '0) ? S_EMIT_OUT : S_EMIT_RD;
            end
            S_EMIT_RD: begin
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.overflowed  = drop_reg;
                    if (best_len_reg == '0) begin
                        m_data_next.out_char     = '0;
                        m_data_next.out_index    = '0;
                        m_data_next.match_length = '0;
                        m_data_next.start_pos    = '0;
                        m_data_next.empty_res    = 1'b1;
                        m_data_next.last         = 1'b1;
                    end else begin
                        m_data_next.out_char     = fs_rdata_reg;
                        m_data_next.out_index    = OUT_IDX_W'(emit_idx_reg);
                        m_data_next.match_length = OUT_LEN_W'(best_len_reg);
                        m_data_next.start_pos    = OUT_POS_W'(start_reg);
                        m_data_next.empty_res    = 1'b0;
                        m_data_next.last         = emit_last;
                    end
                    if (best_len_reg == '0 || emit_last) begin
                        first_count_next  = '0;
                        second_count_next = '0;
                        drop_next         = 1'b0;
                        state_next        = S_IDLE;
                    end else begin
                        emit_idx_next = emit_idx_reg + AW'(1);
                        state_next    = S_EMIT_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            drop_reg         <= 1'b0;
            best_len_reg     <= '0;
            best_end_reg     <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            drop_reg         <= drop_next;
            best_len_reg     <= best_len_next;
            best_end_reg     <= best_end_next;
            m_valid_reg      <= m_valid_next;
        end
        row_reg      <= row_next;
        col_reg      <= col_next;
        diag_reg     <= diag_next;
        start_reg    <= start_next;
        emit_idx_reg <= emit_idx_next;
        m_data_reg   <= m_data_next;
    end

    // ---- assertions ----
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        first_count_reg <= CW'(MAX_LEN) && second_count_reg <= CW'(MAX_LEN))
        else $error("string count above capacity");

    a_best_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |->
            best_len_reg <= first_count_reg && best_len_reg <= second_count_reg)
        else $error("run length exceeds a string length");

    a_compute_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.command == CMD_COMPUTE |=> !s_ready)
        else $error("input still ready after compute transfer");

    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.empty_res |-> m_data.last && m_data.match_length == '0)
        else $error("empty marker malformed");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.empty_res |->
            OUT_LEN_W'(m_data.out_index) < m_data.match_length)
        else $error("substring index beyond match length");

endmodule
